/* sv/grte_pkg.sv */
// ---------------------------------------------------------------------------
// grte_pkg: shared types and constants
// Widths, event codes and register indexes for the pad report event block.
// ---------------------------------------------------------------------------
package grte_pkg;

   localparam int NUM_KEYS   = 16;
   localparam int NUM_AXES   = 6;
   localparam int KEY_W      = 4;
   localparam int AXIS_W     = 3;
   localparam int CNT_W      = 8;
   localparam int RAW_W      = 8;
   localparam int DZ_W       = 7;
   localparam int VAL_W      = 16;
   localparam int Q_W        = 15;
   localparam int NUM_W      = RAW_W + Q_W;
   localparam int DIV_CNT_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0]        KEY_BITS        = 16'((32'd1 << NUM_KEYS) - 32'd1);
   localparam logic [KEY_W-1:0]   LAST_KEY        = KEY_W'(NUM_KEYS - 1);
   localparam logic [AXIS_W-1:0]  LAST_AXIS       = AXIS_W'(NUM_AXES - 1);
   localparam logic [CNT_W-1:0]   INIT_CONN_COUNT = 8'hFF;
   localparam logic [RAW_W-1:0]   FULL_SCALE      = 8'hFF;
   localparam logic signed [VAL_W-1:0] Q_ONE      = 16'sd32767;

   // axis numbering on the event index
   localparam logic [AXIS_W-1:0] AX_LT = 3'd0;
   localparam logic [AXIS_W-1:0] AX_RT = 3'd1;
   localparam logic [AXIS_W-1:0] AX_LX = 3'd2;
   localparam logic [AXIS_W-1:0] AX_LY = 3'd3;
   localparam logic [AXIS_W-1:0] AX_RX = 3'd4;
   localparam logic [AXIS_W-1:0] AX_RY = 3'd5;

   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_RELEASE = 2'd1,
      EV_AXIS    = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DZ_LEFT  = 2'd0,
      CSR_DZ_RIGHT = 2'd1,
      CSR_KEY_MASK = 2'd2
   } csr_idx_type;

   typedef struct packed {
      kind_type                 kind;
      logic [KEY_W-1:0]         index;
      logic signed [VAL_W-1:0]  value;
   } evt_type;

   typedef struct packed {
      logic push;
      logic finish;
   } out_ctl_type;

endpackage

/* sv/grte_req_if.sv */
// ---------------------------------------------------------------------------
// grte_req_if: input channel
// Valid/ready channel carrying one pad report or reset request per beat.
// ---------------------------------------------------------------------------
interface grte_req_if import grte_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic             read_ok;
   logic             connected;
   logic [CNT_W-1:0] connected_count;
   logic [15:0]      button_bits;
   logic [RAW_W-1:0] trigger_left;
   logic [RAW_W-1:0] trigger_right;
   logic [RAW_W-1:0] left_x;
   logic [RAW_W-1:0] left_y;
   logic [RAW_W-1:0] right_x;
   logic [RAW_W-1:0] right_y;

   modport source (
      output valid, req_type, read_ok, connected, connected_count, button_bits,
             trigger_left, trigger_right, left_x, left_y, right_x, right_y,
      input  ready
   );

   modport sink (
      input  valid, req_type, read_ok, connected, connected_count, button_bits,
             trigger_left, trigger_right, left_x, left_y, right_x, right_y,
      output ready
   );
endinterface

/* sv/grte_rsp_if.sv */
// ---------------------------------------------------------------------------
// grte_rsp_if: result channel
// Valid/ready channel carrying one key or axis event per beat.
// ---------------------------------------------------------------------------
interface grte_rsp_if import grte_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              event_kind;
   logic [KEY_W-1:0]        event_index;
   logic signed [VAL_W-1:0] event_value;
   logic                    last_event;

   modport source (
      output valid, event_kind, event_index, event_value, last_event,
      input  ready
   );

   modport sink (
      input  valid, event_kind, event_index, event_value, last_event,
      output ready
   );
endinterface

/* sv/gamepad_report_to_events_core.sv */
// ---------------------------------------------------------------------------
// gamepad_report_to_events_core: pad report to key and axis events
// Flow: a reset request only arms a flush and gives no events. A report runs the
// pending flush first if one is armed, then the connection check, the key edges
// and one divide per axis; a flush item walks keys, then axes. Output stalls hold those steps.
// Throughput: one item at a time; a divide per axis on the shared divider sets it.
// Reset: synchronous, clears the control state; connection count reads as 255.
// ---------------------------------------------------------------------------
module gamepad_report_to_events_core import grte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   grte_req_if.sink              req_bus,
   grte_rsp_if.source            rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [8:0] {
      S_IDLE       = 9'b000000001,
      S_FLUSH_KEYS = 9'b000000010,
      S_FLUSH_AXES = 9'b000000100,
      S_CHECK      = 9'b000001000,
      S_EDGE_KEYS  = 9'b000010000,
      S_AXIS_START = 9'b000100000,
      S_AXIS_WAIT  = 9'b001000000,
      S_AXIS_EMIT  = 9'b010000000,
      S_FINISH     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [DZ_W-1:0]  dz_left_ff, dz_right_ff;
   logic [15:0]      key_mask_ff;

   // block state
   logic [KEY_W-1:0]        idx_ff, idx_in;
   logic [15:0]             held_ff, held_in;
   logic [15:0]             prev_btn_ff, prev_btn_in;
   logic [CNT_W-1:0]        prev_cnt_ff, prev_cnt_in;
   logic                    rst_pend_ff, rst_pend_in;
   logic                    clr_pend_ff, clr_pend_in;
   logic                    pre_ff, pre_in;
   logic                    neg_ff, neg_in;
   logic signed [VAL_W-1:0] axis_ff [NUM_AXES];
   logic signed [VAL_W-1:0] axis_in [NUM_AXES];

   // latched report
   logic             ok_ff, conn_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [15:0]      btn_ff;
   logic [RAW_W-1:0] tl_ff, tr_ff, lx_ff, ly_ff, rx_ff, ry_ff;

   logic             accept;
   logic [AXIS_W-1:0] ax;
   logic [15:0]      mask, cur, prv, chg;
   logic [CNT_W-1:0] count_w;

   // divider operands
   logic [RAW_W-1:0]        raw_sel, dz_sel, d_w, x_w, r_w;
   logic signed [RAW_W+1:0] a_w, dd_w;
   logic                    neg_w;
   logic [NUM_W-1:0]        numer_w;
   logic signed [VAL_W-1:0] val_w;

   logic                    div_start, div_busy, div_done;
   logic [Q_W-1:0]          div_q;

   out_ctl_type             octl;
   evt_type                 evt;
   logic                    out_ready;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign ax            = idx_ff[AXIS_W-1:0];

   assign mask    = key_mask_ff & KEY_BITS;
   assign cur     = btn_ff & mask;
   assign prv     = prev_btn_ff & mask;
   assign chg     = cur ^ prv;
   assign count_w = ok_ff ? cnt_ff : '0;

   // axis operand selection; stick Y is inverted first
   always_comb begin
      case (ax)
         AX_LT:   raw_sel = tl_ff;
         AX_RT:   raw_sel = tr_ff;
         AX_LX:   raw_sel = lx_ff;
         AX_LY:   raw_sel = ~ly_ff;
         AX_RX:   raw_sel = rx_ff;
         AX_RY:   raw_sel = ~ry_ff;
         default: raw_sel = '0;
      endcase
      dz_sel = (ax inside {AX_LX, AX_LY}) ? {1'b0, dz_left_ff} : {1'b0, dz_right_ff};
      d_w    = {dz_sel[DZ_W-1:0], 1'b0};
      a_w    = $signed({1'b0, raw_sel, 1'b0}) - $signed(10'sd255);
      dd_w   = $signed({2'b00, d_w});
      if (ax inside {AX_LT, AX_RT}) begin
         x_w   = raw_sel;
         r_w   = FULL_SCALE;
         neg_w = 1'b0;
      end else begin
         r_w = FULL_SCALE - d_w;
         if (a_w > dd_w) begin
            x_w   = RAW_W'(a_w - dd_w);
            neg_w = 1'b0;
         end else if (a_w < -dd_w) begin
            x_w   = RAW_W'(-a_w - dd_w);
            neg_w = 1'b1;
         end else begin
            x_w   = '0;
            neg_w = 1'b0;
         end
      end
      // x * 32767
      numer_w = {x_w, {Q_W{1'b0}}} - NUM_W'(x_w);
   end

   assign val_w = neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      held_in     = held_ff;
      prev_btn_in = prev_btn_ff;
      prev_cnt_in = prev_cnt_ff;
      rst_pend_in = rst_pend_ff;
      clr_pend_in = clr_pend_ff;
      pre_in      = pre_ff;
      neg_in      = neg_ff;
      axis_in     = axis_ff;
      octl        = '0;
      evt         = '{kind: EV_AXIS, index: '0, value: '0};
      div_start   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = '0;
               if (req_bus.req_type) begin
                  rst_pend_in = 1'b1;
               end else if (rst_pend_ff) begin
                  pre_in   = 1'b1;
                  state_in = S_FLUSH_KEYS;
               end else if (clr_pend_ff) begin
                  held_in     = '0;
                  prev_btn_in = '0;
                  clr_pend_in = 1'b0;
                  for (int i = 0; i < NUM_AXES; i++) axis_in[i] = '0;
                  state_in = S_CHECK;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_FLUSH_KEYS: begin
            if (out_ready) begin
               if (held_ff[idx_ff]) begin
                  octl.push = 1'b1;
                  evt       = '{kind: EV_RELEASE, index: idx_ff, value: '0};
               end
               if (idx_ff == LAST_KEY) begin
                  idx_in   = '0;
                  state_in = S_FLUSH_AXES;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_FLUSH_AXES: begin
            if (out_ready) begin
               if (axis_ff[ax] != '0) begin
                  octl.push = 1'b1;
                  evt       = '{kind: EV_AXIS, index: idx_ff, value: '0};
               end
               if (ax == LAST_AXIS) begin
                  held_in     = '0;
                  rst_pend_in = 1'b0;
                  for (int i = 0; i < NUM_AXES; i++) axis_in[i] = '0;
                  if (pre_ff) begin
                     // pending flush is followed at once by the clear
                     prev_btn_in = '0;
                     clr_pend_in = 1'b0;
                     pre_in      = 1'b0;
                     state_in    = S_CHECK;
                  end else begin
                     clr_pend_in = 1'b1;
                     state_in    = S_FINISH;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_CHECK: begin
            idx_in = '0;
            if (count_w != prev_cnt_ff) begin
               prev_cnt_in = count_w;
               state_in    = S_FLUSH_KEYS;
            end else if (ok_ff && conn_ff) begin
               state_in = S_EDGE_KEYS;
            end else begin
               state_in = S_FLUSH_KEYS;
            end
         end
         S_EDGE_KEYS: begin
            if (out_ready) begin
               if (chg[idx_ff]) begin
                  octl.push = 1'b1;
                  if (cur[idx_ff]) begin
                     held_in[idx_ff] = 1'b1;
                     evt = '{kind: EV_PRESS, index: idx_ff, value: Q_ONE};
                  end else begin
                     held_in[idx_ff] = 1'b0;
                     evt = '{kind: EV_RELEASE, index: idx_ff, value: '0};
                  end
               end
               if (idx_ff == LAST_KEY) begin
                  idx_in      = '0;
                  prev_btn_in = btn_ff;
                  state_in    = S_AXIS_START;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_AXIS_START: begin
            div_start = 1'b1;
            neg_in    = neg_w;
            state_in  = S_AXIS_WAIT;
         end
         S_AXIS_WAIT: begin
            if (div_done) state_in = S_AXIS_EMIT;
         end
         S_AXIS_EMIT: begin
            if (out_ready) begin
               if (val_w != '0 || axis_ff[ax] != '0) begin
                  octl.push = 1'b1;
                  evt       = '{kind: EV_AXIS, index: idx_ff, value: val_w};
               end
               axis_in[ax] = val_w;
               if (ax == LAST_AXIS) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_AXIS_START;
               end
            end
         end
         S_FINISH: begin
            octl.finish = 1'b1;
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= '0;
         held_ff     <= '0;
         prev_btn_ff <= '0;
         prev_cnt_ff <= INIT_CONN_COUNT;
         rst_pend_ff <= 1'b0;
         clr_pend_ff <= 1'b0;
         pre_ff      <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) axis_ff[i] <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         held_ff     <= held_in;
         prev_btn_ff <= prev_btn_in;
         prev_cnt_ff <= prev_cnt_in;
         rst_pend_ff <= rst_pend_in;
         clr_pend_ff <= clr_pend_in;
         pre_ff      <= pre_in;
         axis_ff     <= axis_in;
      end
      neg_ff <= neg_in;
      if (accept) begin
         ok_ff   <= req_bus.read_ok;
         conn_ff <= req_bus.connected;
         cnt_ff  <= req_bus.connected_count;
         btn_ff  <= req_bus.button_bits;
         tl_ff   <= req_bus.trigger_left;
         tr_ff   <= req_bus.trigger_right;
         lx_ff   <= req_bus.left_x;
         ly_ff   <= req_bus.left_y;
         rx_ff   <= req_bus.right_x;
         ry_ff   <= req_bus.right_y;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dz_left_ff  <= '0;
         dz_right_ff <= '0;
         key_mask_ff <= 16'hFFFF;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DZ_LEFT:  dz_left_ff  <= csr_wdata[DZ_W-1:0];
            CSR_DZ_RIGHT: dz_right_ff <= csr_wdata[DZ_W-1:0];
            CSR_KEY_MASK: key_mask_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   grte_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .numer   (numer_w),
      .divisor (r_w),
      .busy    (div_busy),
      .done    (div_done),
      .quot    (div_q)
   );

   grte_out u_out (
      .clock   (clock),
      .reset   (reset),
      .ctl     (octl),
      .evt     (evt),
      .ready   (out_ready),
      .rsp_bus (rsp_bus)
   );

   a_check_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (!rst_pend_ff && !clr_pend_ff))
      else $error("pending flag still set at connection check");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AXIS_START) |=> div_busy)
      else $error("divider did not start for axis");

endmodule

/* sv/grte_div.sv */
// ---------------------------------------------------------------------------
// grte_div: shared restoring divider
// One quotient bit per cycle; the quotient is known to fit in Q_W bits.
// ---------------------------------------------------------------------------
module grte_div import grte_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [RAW_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [Q_W-1:0]   quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAW_W-1:0]     rem_ff, rem_in;
   logic [RAW_W-1:0]     dvs_ff, dvs_in;
   logic [Q_W-1:0]       num_ff, num_in;
   logic [Q_W-1:0]       q_ff, q_in;
   logic [RAW_W:0]       trial;
   logic [RAW_W:0]       diff;
   logic                 ge;

   assign trial = {rem_ff, num_ff[Q_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      num_in  = num_ff;
      q_in    = q_ff;
      if (start) begin
         // upper part is below the divisor, so no overflow bit is lost
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(Q_W - 1);
         rem_in  = numer[NUM_W-1:Q_W];
         num_in  = numer[Q_W-1:0];
         dvs_in  = divisor;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
         q_in   = {q_ff[Q_W-2:0], ge};
         num_in = {num_ff[Q_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      num_ff <= num_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

/* sv/grte_out.sv */
// ---------------------------------------------------------------------------
// grte_out: event output stage
// Holds one event back so the final event of an item can be flagged, and
// drives the result channel from a register.
// ---------------------------------------------------------------------------
module grte_out import grte_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  out_ctl_type ctl,
   input  evt_type     evt,
   output logic        ready,
   grte_rsp_if.source  rsp_bus
);

   logic    pend_valid_ff, pend_valid_in;
   evt_type pend_ff, pend_in;
   logic    out_valid_ff, out_valid_in;
   evt_type out_ff, out_in;
   logic    out_last_ff, out_last_in;
   logic    out_free;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign ready    = !pend_valid_ff || out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      if (ctl.push && ready) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = evt;
      end else if (ctl.finish && ready && pend_valid_ff) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.event_kind  = out_ff.kind;
   assign rsp_bus.event_index = out_ff.index;
   assign rsp_bus.event_value = out_ff.value;
   assign rsp_bus.last_event  = out_last_ff;

   a_push_ready: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> ready)
      else $error("event pushed while output stage full");

   a_finish_drains: assert property (@(posedge clock) disable iff (reset)
      (ctl.finish && ready) |=> !pend_valid_ff)
      else $error("held event left behind at end of item");

endmodule

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// tb: testbench for gamepad_report_to_events_core
// Drives pad reports and reset requests through the request channel and
// checks each key and axis event beat against an in-bench model of the
// dead-zone scaling, button edge and flush logic. A directed table comes
// first, then random report streams under several register settings, with
// random stalls on both channels and a long hold-off on the event side.
// ---------------------------------------------------------------------------
module tb import grte_pkg::*; ();

   localparam int RESET_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = 200;   // covers a report plus a pending flush
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int QUIET_LIMIT     = 3000;
   localparam int NUM_PHASES      = 5;
   localparam int PHASE_ITEMS     = 60;
   localparam int UNCHECKED       = -1;

   localparam logic REQ_REPORT = 1'b0;
   localparam logic REQ_RESET  = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic             req_type;
      logic             read_ok;
      logic             connected;
      logic [CNT_W-1:0] gen;
      logic [15:0]      buttons;
      logic [RAW_W-1:0] lt;
      logic [RAW_W-1:0] rt;
      logic [RAW_W-1:0] lx;
      logic [RAW_W-1:0] ly;
      logic [RAW_W-1:0] rx;
      logic [RAW_W-1:0] ry;
   } pad_item_type;

   typedef struct packed {
      kind_type                kind;
      logic [KEY_W-1:0]        index;
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } pad_event_type;

   // hand-worked outcome of a table row: event count and the final event
   typedef struct {
      int       count;
      kind_type kind;
      int       index;
      int       value;
   } spot_type;

   typedef struct {
      pad_item_type item;
      spot_type     spot;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   grte_req_if req_bus ();
   grte_rsp_if rsp_bus ();

   gamepad_report_to_events_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state and register mirror
   logic [15:0]             seen_buttons;
   logic [15:0]             down_keys;
   logic signed [VAL_W-1:0] axis_level [NUM_AXES];
   logic [CNT_W-1:0]        last_gen;
   logic                    flush_armed;
   logic                    wipe_armed;
   logic [DZ_W-1:0]         dz_left_cfg;
   logic [DZ_W-1:0]         dz_right_cfg;
   logic [15:0]             key_mask_cfg;

   pad_event_type step_events [$];
   pad_event_type due_events [$];
   spot_type      spot_checks [$];
   stim_row_type  plan_rows [$];

   int   errors       = 0;
   int   req_beats    = 0;
   int   reset_reqs   = 0;
   int   event_beats  = 0;
   int   settings_run = 0;
   logic send_gaps    = 1'b0;
   logic recv_stalls  = 1'b0;
   logic hold_off_req = 1'b0;

   // stimulus-side stream state
   logic [CNT_W-1:0] link_gen    = INIT_CONN_COUNT;
   logic [15:0]      pad_buttons = '0;

   // ---------------- event model ----------------

   function automatic int trig_q15(logic [RAW_W-1:0] raw);
      return (int'(raw) * 32767) / 255;
   endfunction

   function automatic int stick_q15(logic [RAW_W-1:0] raw, logic [DZ_W-1:0] dz);
      int a, d, r;
      a = 2 * int'(raw) - 255;
      d = 2 * int'(dz);
      r = 255 - d;
      if (a > d) return ((a - d) * 32767) / r;
      if (a < -d) return -(((-a - d) * 32767) / r);
      return 0;
   endfunction

   function automatic void emit_event(kind_type k, logic [KEY_W-1:0] idx,
                                      logic signed [VAL_W-1:0] v);
      pad_event_type e;
      e.kind  = k;
      e.index = idx;
      e.value = v;
      e.last  = 1'b0;
      step_events.push_back(e);
   endfunction

   // releases for held keys, zeros for live axes, then a clear is owed
   function automatic void flush_held();
      int k;
      for (k = 0; k < NUM_KEYS; k++)
         if (down_keys[k]) emit_event(EV_RELEASE, KEY_W'(k), '0);
      for (k = 0; k < NUM_AXES; k++)
         if (axis_level[k] != 0) emit_event(EV_AXIS, KEY_W'(k), '0);
      down_keys = '0;
      for (k = 0; k < NUM_AXES; k++) axis_level[k] = '0;
      flush_armed = 1'b0;
      wipe_armed  = 1'b1;
   endfunction

   function automatic void axis_update(logic [AXIS_W-1:0] ax, int v);
      logic signed [VAL_W-1:0] old;
      old = axis_level[ax];
      axis_level[ax] = VAL_W'(v);
      if (v != 0 || old != 0) emit_event(EV_AXIS, KEY_W'(ax), VAL_W'(v));
   endfunction

   function automatic void predict_events(pad_item_type it);
      logic [CNT_W-1:0] gen;
      logic [15:0] live, was, flip;
      int k;
      step_events.delete();
      if (it.req_type == REQ_RESET) begin
         flush_armed = 1'b1;
         return;
      end
      gen = it.read_ok ? it.gen : '0;
      if (flush_armed) flush_held();
      if (wipe_armed) begin
         down_keys    = '0;
         seen_buttons = '0;
         for (k = 0; k < NUM_AXES; k++) axis_level[k] = '0;
         wipe_armed  = 1'b0;
         flush_armed = 1'b0;
      end
      if (gen != last_gen) begin
         last_gen = gen;
         flush_held();
      end else if (it.read_ok && it.connected) begin
         live = it.buttons & key_mask_cfg & KEY_BITS;
         was  = seen_buttons & key_mask_cfg & KEY_BITS;
         flip = live ^ was;
         for (k = 0; k < NUM_KEYS; k++) begin
            if (flip[k] && live[k]) begin
               down_keys[k] = 1'b1;
               emit_event(EV_PRESS, KEY_W'(k), Q_ONE);
            end else if (flip[k]) begin
               down_keys[k] = 1'b0;
               emit_event(EV_RELEASE, KEY_W'(k), '0);
            end
         end
         axis_update(AX_LT, trig_q15(it.lt));
         axis_update(AX_RT, trig_q15(it.rt));
         axis_update(AX_LX, stick_q15(it.lx, dz_left_cfg));
         axis_update(AX_LY, stick_q15(FULL_SCALE - it.ly, dz_left_cfg));
         axis_update(AX_RX, stick_q15(it.rx, dz_right_cfg));
         axis_update(AX_RY, stick_q15(FULL_SCALE - it.ry, dz_right_cfg));
         seen_buttons = it.buttons;
         last_gen     = gen;
      end else begin
         flush_held();
      end
      if (step_events.size() > 0) step_events[$].last = 1'b1;
      for (k = 0; k < step_events.size(); k++) due_events.push_back(step_events[k]);
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic pad_item_type report_item(logic ok, logic conn, logic [CNT_W-1:0] gen,
                                                logic [15:0] btn, logic [RAW_W-1:0] lt,
                                                logic [RAW_W-1:0] rt, logic [RAW_W-1:0] lx,
                                                logic [RAW_W-1:0] ly, logic [RAW_W-1:0] rx,
                                                logic [RAW_W-1:0] ry);
      pad_item_type it;
      it.req_type  = REQ_REPORT;
      it.read_ok   = ok;
      it.connected = conn;
      it.gen       = gen;
      it.buttons   = btn;
      it.lt        = lt;
      it.rt        = rt;
      it.lx        = lx;
      it.ly        = ly;
      it.rx        = rx;
      it.ry        = ry;
      return it;
   endfunction

   // payload of a reset request is don't-care, so fill it with noise
   function automatic pad_item_type reset_req();
      logic [95:0]  noise;
      pad_item_type it;
      noise       = {$urandom(), $urandom(), $urandom()};
      it          = noise[$bits(pad_item_type)-1:0];
      it.req_type = REQ_RESET;
      return it;
   endfunction

   function automatic spot_type spot(int n, kind_type k, int idx, int v);
      spot_type s;
      s.count = n;
      s.kind  = k;
      s.index = idx;
      s.value = v;
      return s;
   endfunction

   function automatic logic [RAW_W-1:0] pick_raw();
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2: return FULL_SCALE;
         3: return 8'd128;
         4: return 8'd127;
         default: return RAW_W'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly well-formed reports on a stable link, with a few
   // generation changes, failed reads, disconnects and reset requests
   function automatic pad_item_type random_item();
      pad_item_type it;
      int pick, b;
      pick = $urandom_range(0, 99);
      if (pick < 6) return reset_req();
      if ($urandom_range(0, 7) == 0) begin
         pad_buttons = 16'($urandom());
      end else begin
         b = $urandom_range(0, 15);
         pad_buttons[b] = ~pad_buttons[b];
         if ($urandom_range(0, 1) == 1) begin
            b = $urandom_range(0, 15);
            pad_buttons[b] = ~pad_buttons[b];
         end
      end
      if (pick < 11) link_gen = CNT_W'($urandom());
      it = report_item(1'b1, 1'b1, link_gen, pad_buttons, pick_raw(), pick_raw(),
                       pick_raw(), pick_raw(), pick_raw(), pick_raw());
      if (pick >= 11 && pick < 15) begin
         it.read_ok = 1'b0;
         it.gen     = CNT_W'($urandom());
      end else if (pick >= 15 && pick < 19) begin
         it.connected = 1'b0;
      end
      return it;
   endfunction

   task automatic add_row(pad_item_type it, spot_type s);
      stim_row_type r;
      r.item = it;
      r.spot = s;
      plan_rows.push_back(r);
   endtask

   task automatic offer(pad_item_type it, spot_type s);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      spot_checks.push_back(s);
      req_bus.valid           <= 1'b1;
      req_bus.req_type        <= it.req_type;
      req_bus.read_ok         <= it.read_ok;
      req_bus.connected       <= it.connected;
      req_bus.connected_count <= it.gen;
      req_bus.button_bits     <= it.buttons;
      req_bus.trigger_left    <= it.lt;
      req_bus.trigger_right   <= it.rt;
      req_bus.left_x          <= it.lx;
      req_bus.left_y          <= it.ly;
      req_bus.right_x         <= it.rx;
      req_bus.right_y         <= it.ry;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(logic [DZ_W-1:0] dzl, logic [DZ_W-1:0] dzr,
                               logic [15:0] mask);
      write_reg(CSR_DZ_LEFT, CSR_DATA_W'(dzl));
      write_reg(CSR_DZ_RIGHT, CSR_DATA_W'(dzr));
      write_reg(CSR_KEY_MASK, mask);
      csr_wr_en <= 1'b0;
      settings_run++;
   endtask

   // stop offering, wait out all events, then long enough for a silent item
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (due_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic field_check(string what, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // ---------------- scoreboard ----------------

   always @(posedge clock) begin : scoreboard
      pad_event_type want;
      pad_item_type  seen;
      spot_type      s;
      int            k;
      if (reset) begin
         seen_buttons = '0;
         down_keys    = '0;
         for (k = 0; k < NUM_AXES; k++) axis_level[k] = '0;
         last_gen     = INIT_CONN_COUNT;
         flush_armed  = 1'b0;
         wipe_armed   = 1'b0;
         dz_left_cfg  = '0;
         dz_right_cfg = '0;
         key_mask_cfg = 16'hFFFF;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DZ_LEFT:  dz_left_cfg  = csr_wdata[DZ_W-1:0];
               CSR_DZ_RIGHT: dz_right_cfg = csr_wdata[DZ_W-1:0];
               CSR_KEY_MASK: key_mask_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            event_beats++;
            if (due_events.size() == 0) begin
               errors++;
               $display({"%0t: unexpected event beat, expected none, ",
                         "got kind %0d index %0d value %0d last %0b"},
                        $time, rsp_bus.event_kind, rsp_bus.event_index,
                        rsp_bus.event_value, rsp_bus.last_event);
            end else begin
               want = due_events.pop_front();
               field_check("event_kind", 32'(want.kind), 32'(rsp_bus.event_kind));
               field_check("event_index", 32'(want.index), 32'(rsp_bus.event_index));
               field_check("event_value", want.value, rsp_bus.event_value);
               field_check("last_event", 32'(want.last), 32'(rsp_bus.last_event));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.req_type  = req_bus.req_type;
            seen.read_ok   = req_bus.read_ok;
            seen.connected = req_bus.connected;
            seen.gen       = req_bus.connected_count;
            seen.buttons   = req_bus.button_bits;
            seen.lt        = req_bus.trigger_left;
            seen.rt        = req_bus.trigger_right;
            seen.lx        = req_bus.left_x;
            seen.ly        = req_bus.left_y;
            seen.rx        = req_bus.right_x;
            seen.ry        = req_bus.right_y;
            req_beats++;
            if (seen.req_type == REQ_RESET) reset_reqs++;
            predict_events(seen);
            if (spot_checks.size() > 0) begin
               s = spot_checks.pop_front();
               if (s.count != UNCHECKED) begin
                  if (step_events.size() != s.count) begin
                     errors++;
                     $display("%0t: table row event count, expected %0d, got %0d",
                              $time, s.count, step_events.size());
                  end else if (s.count > 0 &&
                               (step_events[$].kind != s.kind ||
                                step_events[$].index != KEY_W'(s.index) ||
                                step_events[$].value != VAL_W'(s.value))) begin
                     errors++;
                     $display({"%0t: table row final event, ",
                               "expected %0d/%0d/%0d, got %0d/%0d/%0d"},
                              $time, s.kind, s.index, s.value, step_events[$].kind,
                              step_events[$].index, step_events[$].value);
                  end
               end
            end
         end
      end
   end

   // ---------------- event side ready ----------------

   initial begin : receiver
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no beat on either channel for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------- main sequence ----------------

   initial begin : stimulus
      int phase, n;
      reset                   <= 1'b1;
      csr_wr_en               <= 1'b0;
      csr_index               <= '0;
      csr_wdata               <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.req_type        <= REQ_REPORT;
      req_bus.read_ok         <= 1'b0;
      req_bus.connected       <= 1'b0;
      req_bus.connected_count <= '0;
      req_bus.button_bits     <= '0;
      req_bus.trigger_left    <= '0;
      req_bus.trigger_right   <= '0;
      req_bus.left_x          <= '0;
      req_bus.left_y          <= '0;
      req_bus.right_x         <= '0;
      req_bus.right_y         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full dead zones make every stick zero except the raw extremes
      send_gaps   = 1'b1;
      recv_stalls = 1'b1;
      write_reg(CSR_SPARE, 16'hFFFF);
      program_regs(7'd127, 7'd127, 16'hFFFF);

      add_row(reset_req(), spot(0, EV_PRESS, 0, 0));
      add_row(report_item(1, 1, 8'hFF, 16'h0000, 0, 0, 128, 128, 128, 128),
              spot(0, EV_PRESS, 0, 0));
      add_row(report_item(1, 1, 8'hFF, 16'h0001, 255, 0, 128, 128, 128, 128),
              spot(2, EV_AXIS, AX_LT, 32767));
      add_row(report_item(1, 1, 8'hFF, 16'h8000, 0, 0, 128, 128, 128, 128),
              spot(3, EV_AXIS, AX_LT, 0));
      add_row(report_item(1, 1, 8'hFF, 16'hFFFF, 255, 255, 255, 0, 0, 255),
              spot(21, EV_AXIS, AX_RY, -32767));
      add_row(reset_req(), spot(0, EV_PRESS, 0, 0));
      // pending flush, then every key and axis again: the longest burst
      add_row(report_item(1, 1, 8'hFF, 16'hFFFF, 255, 255, 255, 0, 0, 255),
              spot(44, EV_AXIS, AX_RY, -32767));
      add_row(report_item(1, 1, 8'h07, 16'hFFFF, 255, 255, 255, 0, 0, 255),
              spot(22, EV_AXIS, AX_RY, 0));
      add_row(report_item(1, 1, 8'h07, 16'h0000, 0, 0, 128, 128, 128, 128),
              spot(0, EV_PRESS, 0, 0));
      add_row(report_item(1, 1, 8'h07, 16'h00FF, 128, 1, 0, 254, 254, 1),
              spot(UNCHECKED, EV_PRESS, 0, 0));
      add_row(report_item(0, 1, 8'h07, 16'h00FF, 128, 1, 0, 254, 254, 1),
              spot(UNCHECKED, EV_PRESS, 0, 0));
      add_row(report_item(0, 1, 8'hC8, 16'h0000, 0, 0, 128, 128, 128, 128),
              spot(0, EV_PRESS, 0, 0));
      add_row(report_item(1, 0, 8'h00, 16'h0F0F, 9, 9, 255, 0, 255, 0),
              spot(0, EV_PRESS, 0, 0));
      add_row(report_item(1, 1, 8'h00, 16'hAAAA, 1, 254, 255, 255, 0, 0),
              spot(UNCHECKED, EV_PRESS, 0, 0));
      add_row(reset_req(), spot(0, EV_PRESS, 0, 0));
      add_row(reset_req(), spot(0, EV_PRESS, 0, 0));
      add_row(report_item(1, 1, 8'h00, 16'h5555, 0, 0, 128, 128, 128, 128),
              spot(UNCHECKED, EV_PRESS, 0, 0));
      add_row(report_item(1, 1, 8'hFF, 16'h5555, 0, 0, 128, 128, 128, 128),
              spot(UNCHECKED, EV_PRESS, 0, 0));
      add_row(report_item(1, 1, 8'hFF, 16'hFFFF, 255, 255, 0, 255, 255, 0),
              spot(UNCHECKED, EV_PRESS, 0, 0));
      for (n = 0; n < plan_rows.size(); n++) offer(plan_rows[n].item, plan_rows[n].spot);

      link_gen    = 8'hFF;
      pad_buttons = 16'hFFFF;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         case (phase)
            0: begin
               program_regs(7'd0, 7'd0, 16'hFFFF);
               send_gaps = 1'b1; recv_stalls = 1'b1;
            end
            1: begin
               program_regs(7'd127, 7'd0, 16'($urandom()));
               send_gaps = 1'b1; recv_stalls = 1'b0;
            end
            2: begin
               program_regs(7'($urandom()), 7'd127, 16'h0000);
               send_gaps = 1'b0; recv_stalls = 1'b1;
            end
            3: begin
               program_regs(7'($urandom()), 7'($urandom()), 16'($urandom()));
               send_gaps = 1'b1; recv_stalls = 1'b1;
            end
            default: begin
               // closing stretch runs flat out on both sides
               program_regs(7'd1, 7'd126, 16'hFFFF);
               send_gaps = 1'b0; recv_stalls = 1'b0;
            end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // event side stops while reports keep coming, so the core backs up
            if (phase == 1 && n == 8) hold_off_req = 1'b1;
            offer(random_item(), spot(UNCHECKED, EV_PRESS, 0, 0));
         end
      end
      req_bus.valid <= 1'b0;
      settle();

      if (due_events.size() != 0) begin
         errors++;
         $display("%0t: %0d expected event beats never arrived", $time, due_events.size());
      end
      $display("Covered %0d request beats (%0d reset requests) and %0d event beats",
               req_beats, reset_reqs, event_beats);
      $display("across %0d register settings, dead zones and key masks at both ends.",
               settings_run);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
